// ===== sv/bsa_pkg.sv =====
// shared types, codes and default sizes of the banker's safety allocator
package bsa_pkg;

  // default storage bounds
  localparam int unsigned MAX_PROCS_DEF = 16;
  localparam int unsigned MAX_RES_DEF   = 16;

  // fixed field widths
  localparam int unsigned VW     = 16;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 5;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_NUM_PROCS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_NUM_RES   = 2'd1;

  // result status codes
  localparam logic [ST_W-1:0] ST_SAFE    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNSAFE  = 2'd1;
  localparam logic [ST_W-1:0] ST_EXCEEDS = 2'd2;
  localparam logic [ST_W-1:0] ST_WAIT    = 2'd3;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WR_AVAIL = 3'd0,
    OP_WR_MAX   = 3'd1,
    OP_WR_ALLOC = 3'd2,
    OP_CHECK    = 3'd3,
    OP_REQUEST  = 3'd4
  } op_e;

  // command word into the engine
  typedef struct packed {
    logic             start;
    op_e              op;
    logic [IDX_W-1:0] proc_idx;
    logic [IDX_W-1:0] res_idx;
    logic [VW-1:0]    value;
    logic             last;
  } cmd_t;

  // result word out of the engine
  typedef struct packed {
    logic             valid;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] proc_idx;
    logic             last;
  } res_t;

endpackage

// ===== sv/bankers_safety_allocator_core.sv =====
// Banker's deadlock-avoidance engine. After reset the claim and allocation memories are
// cleared, one entry a cycle, every entry (256 at the default sizes) with busy_o high. A
// load word and a non-last request element leave busy_o low. A safety check scans rows in
// passes, with one memory read per element of an unfinished row; a finished row is
// skipped, and a safe sequence is delivered as n words. A request adds a scan of its m
// elements, a write-back of m allocation entries on grant and m more on rollback. Results
// come on consecutive cycles, each for one cycle under result_valid_o; the receiver cannot
// stall.
module bankers_safety_allocator_core import bsa_pkg::*; #(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF,
  parameter int unsigned MAX_RES   = MAX_RES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [IDX_W-1:0]  process_i,
  input  logic [IDX_W-1:0]  resource_i,
  input  logic [VW-1:0]     value_i,
  input  logic              request_last_i,
  output logic              result_valid_o,
  output logic [ST_W-1:0]   status_o,
  output logic [IDX_W-1:0]  process_index_o,
  output logic              last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned MW = $clog2(MAX_RES + 1);

  logic [CFG_DW-1:0] num_procs_q, num_res_q;
  logic [CW-1:0]     n_eff;
  logic [MW-1:0]     m_eff;
  cmd_t              cmd;
  res_t              res;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_procs_q <= CFG_DW'(5);
      num_res_q   <= CFG_DW'(3);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NUM_PROCS: num_procs_q <= cfg_data_i;
        CFG_NUM_RES:   num_res_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counts in use, clamped to one and to storage
  always_comb begin
    if (num_procs_q == '0) n_eff = CW'(1);
    else if (32'(num_procs_q) > MAX_PROCS) n_eff = CW'(MAX_PROCS);
    else n_eff = CW'(num_procs_q);
    if (num_res_q == '0) m_eff = MW'(1);
    else if (32'(num_res_q) > MAX_RES) m_eff = MW'(MAX_RES);
    else m_eff = MW'(num_res_q);
  end

  // command word
  assign cmd.start    = start_i;
  assign cmd.op       = op_e'(operation_i);
  assign cmd.proc_idx = process_i;
  assign cmd.res_idx  = resource_i;
  assign cmd.value    = value_i;
  assign cmd.last     = request_last_i;

  bsa_engine #(.MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES)) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .n_i   (n_eff),
    .m_i   (m_eff),
    .busy_o(busy_o),
    .res_o (res)
  );

  assign result_valid_o  = res.valid;
  assign status_o        = res.status;
  assign process_index_o = res.proc_idx;
  assign last_o          = res.last;

`ifndef SYNTHESIS
  // a safe sequence is delivered without gaps
  a_seq_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("safe sequence interrupted");

  // every non-safe outcome is a single closing word with index zero
  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_SAFE) |-> last_o && (process_index_o == '0))
    else $error("non-safe result not final");

  // a safety check always occupies the engine
  a_check_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (operation_i == OP_CHECK) |=> busy_o)
    else $error("check accepted without busy");
`endif

endmodule

// ===== sv/bsa_ram.sv =====
// single-port-write, registered-read matrix memory
module bsa_ram import bsa_pkg::*; #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = VW
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bsa_engine.sv =====
// sequencer for loads, requests and safety checks over the claim and allocation memories
module bsa_engine import bsa_pkg::*; #(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF,
  parameter int unsigned MAX_RES   = MAX_RES_DEF,
  localparam int unsigned PW = $clog2(MAX_PROCS),
  localparam int unsigned RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1,
  localparam int unsigned CW = $clog2(MAX_PROCS + 1),
  localparam int unsigned MW = $clog2(MAX_RES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic [CW-1:0] n_i,
  input  logic [MW-1:0] m_i,
  output logic          busy_o,
  output res_t          res_o
);

  localparam int unsigned AW = PW + RW;
  localparam int unsigned WW = VW + $clog2(MAX_PROCS + 1);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_REQ_SCAN = 11'b00000000100,
    S_GRANT    = 11'b00000001000,
    S_CHK_INIT = 11'b00000010000,
    S_CHK_ROW  = 11'b00000100000,
    S_CHK_SCAN = 11'b00001000000,
    S_CHK_NEXT = 11'b00010000000,
    S_ROLLBACK = 11'b00100000000,
    S_EMIT     = 11'b01000000000,
    S_FAIL     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [VW-1:0] avail_q [MAX_RES];
  logic [VW-1:0] req_q   [MAX_RES];
  logic [VW-1:0] orig_q  [MAX_RES];
  logic [VW-1:0] row_q   [MAX_RES];
  logic [WW-1:0] work_q  [MAX_RES];
  logic [PW-1:0] seq_q   [MAX_PROCS];
  logic          fin_q   [MAX_PROCS];

  logic [AW-1:0]   clr_cnt_q;
  logic [MW-1:0]   j_q;
  logic [RW-1:0]   jd_q;
  logic            rv_q;
  logic [PW-1:0]   i_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   k_q;
  logic            prog_q;
  logic            cb_q;
  logic            wb_q;
  logic            in_req_q;
  logic [PW-1:0]   req_p_q;
  logic [ST_W-1:0] fail_st_q;
  logic            res_vld_q;
  logic [ST_W-1:0] res_st_q;
  logic [IDX_W-1:0] res_idx_q;
  logic            res_last_q;

  // memory ports
  logic          max_we, alc_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [VW-1:0] max_wd, alc_wd, max_rd, alc_rd;

  // decoded command
  logic          accept, r_ok, p_ok, p_in_use;
  logic [PW-1:0] cmd_p;
  logic [RW-1:0] cmd_r;

  // scan datapath
  logic               issue, data_last, j_last, i_last, all_done;
  logic signed [VW:0] need_s;
  logic               work_fail, req_over_need, req_over_av;
  logic               bad_c, bad_w, row_fail, row_fit;

  bsa_ram #(.AW(AW), .DW(VW)) u_max_ram (
    .clk_i  (clk_i),
    .we_i   (max_we),
    .waddr_i(wr_addr),
    .wdata_i(max_wd),
    .raddr_i(rd_addr),
    .rdata_o(max_rd)
  );

  bsa_ram #(.AW(AW), .DW(VW)) u_alc_ram (
    .clk_i  (clk_i),
    .we_i   (alc_we),
    .waddr_i(wr_addr),
    .wdata_i(alc_wd),
    .raddr_i(rd_addr),
    .rdata_o(alc_rd)
  );

  // command decode
  assign accept   = cmd_i.start && (state_q == S_IDLE);
  assign r_ok     = 32'(cmd_i.res_idx) < MAX_RES;
  assign p_ok     = 32'(cmd_i.proc_idx) < MAX_PROCS;
  assign p_in_use = 32'(cmd_i.proc_idx) < 32'(n_i);
  assign cmd_p    = PW'(cmd_i.proc_idx);
  assign cmd_r    = RW'(cmd_i.res_idx);

  // element compares on the word returned by the memories
  assign need_s        = $signed({1'b0, max_rd}) - $signed({1'b0, alc_rd});
  assign work_fail     = $signed({{(WW - VW){need_s[VW]}}, need_s}) >
                         $signed({1'b0, work_q[jd_q]});
  assign req_over_need = $signed({1'b0, req_q[jd_q]}) > need_s;
  assign req_over_av   = req_q[jd_q] > avail_q[jd_q];
  assign bad_c         = cb_q || req_over_need;
  assign bad_w         = wb_q || req_over_av;
  assign row_fail      = rv_q && work_fail;
  assign row_fit       = rv_q && !work_fail && data_last;

  assign data_last = (MW'(jd_q) == m_i - MW'(1));
  assign j_last    = (j_q == m_i - MW'(1));
  assign i_last    = (CW'(i_q) == n_i - CW'(1));
  assign all_done  = (cnt_q == n_i);
  assign issue     = ((state_q == S_REQ_SCAN) || (state_q == S_CHK_SCAN)) && (j_q < m_i);

  // read address follows the scanned process
  always_comb begin
    if (state_q == S_REQ_SCAN) begin
      rd_addr = {req_p_q, j_q[RW-1:0]};
    end else begin
      rd_addr = {i_q, j_q[RW-1:0]};
    end
  end

  // memory write port selection
  always_comb begin
    max_we  = 1'b0;
    alc_we  = 1'b0;
    wr_addr = {cmd_p, cmd_r};
    max_wd  = cmd_i.value;
    alc_wd  = cmd_i.value;
    unique case (state_q)
      S_CLEAR: begin
        max_we  = 1'b1;
        alc_we  = 1'b1;
        wr_addr = clr_cnt_q;
        max_wd  = '0;
        alc_wd  = '0;
      end
      S_IDLE: begin
        max_we = accept && (cmd_i.op == OP_WR_MAX) && r_ok && p_ok;
        alc_we = accept && (cmd_i.op == OP_WR_ALLOC) && r_ok && p_ok;
      end
      S_GRANT: begin
        alc_we  = 1'b1;
        wr_addr = {req_p_q, j_q[RW-1:0]};
        alc_wd  = orig_q[j_q[RW-1:0]] + req_q[j_q[RW-1:0]];
      end
      S_ROLLBACK: begin
        alc_we  = 1'b1;
        wr_addr = {req_p_q, j_q[RW-1:0]};
        alc_wd  = orig_q[j_q[RW-1:0]];
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:    if (&clr_cnt_q) state_d = S_IDLE;
      S_IDLE: begin
        if (accept && (cmd_i.op == OP_CHECK)) begin
          state_d = S_CHK_INIT;
        end else if (accept && (cmd_i.op == OP_REQUEST) && cmd_i.last) begin
          state_d = p_in_use ? S_REQ_SCAN : S_FAIL;
        end
      end
      S_REQ_SCAN: begin
        if (rv_q && data_last) state_d = (bad_c || bad_w) ? S_FAIL : S_GRANT;
      end
      S_GRANT:    if (j_last) state_d = S_CHK_INIT;
      S_CHK_INIT: state_d = S_CHK_ROW;
      S_CHK_ROW:  state_d = fin_q[i_q] ? S_CHK_NEXT : S_CHK_SCAN;
      S_CHK_SCAN: if (row_fail || row_fit) state_d = S_CHK_NEXT;
      S_CHK_NEXT: begin
        if (!i_last) begin
          state_d = S_CHK_ROW;
        end else if (all_done) begin
          state_d = S_EMIT;
        end else if (!prog_q) begin
          state_d = in_req_q ? S_ROLLBACK : S_FAIL;
        end else begin
          state_d = S_CHK_ROW;
        end
      end
      S_ROLLBACK: if (j_last) state_d = S_FAIL;
      S_EMIT:     if (k_q == n_i - CW'(1)) state_d = S_IDLE;
      S_FAIL:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // control registers and available vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      j_q       <= '0;
      rv_q      <= 1'b0;
      i_q       <= '0;
      cnt_q     <= '0;
      k_q       <= '0;
      prog_q    <= 1'b0;
      cb_q      <= 1'b0;
      wb_q      <= 1'b0;
      in_req_q  <= 1'b0;
      req_p_q   <= '0;
      res_vld_q <= 1'b0;
      for (int j = 0; j < MAX_RES; j++) avail_q[j] <= '0;
    end else begin
      state_q   <= state_d;
      rv_q      <= issue;
      res_vld_q <= (state_q == S_EMIT) || (state_q == S_FAIL);
      if (issue) j_q <= j_q + MW'(1);
      unique case (state_q)
        S_CLEAR: clr_cnt_q <= clr_cnt_q + AW'(1);
        S_IDLE: begin
          j_q     <= '0;
          cb_q    <= 1'b0;
          wb_q    <= 1'b0;
          req_p_q <= cmd_p;
          if (accept && (cmd_i.op == OP_WR_AVAIL) && r_ok) avail_q[cmd_r] <= cmd_i.value;
          if (accept && (cmd_i.op == OP_CHECK)) in_req_q <= 1'b0;
        end
        S_REQ_SCAN: begin
          if (rv_q) begin
            cb_q <= bad_c;
            wb_q <= bad_w;
          end
          // tentative grant on the available side
          if (rv_q && data_last) begin
            j_q <= '0;
            if (!bad_c && !bad_w) begin
              for (int j = 0; j < MAX_RES; j++) begin
                if (j < 32'(m_i)) avail_q[j] <= avail_q[j] - req_q[j];
              end
            end
          end
        end
        S_GRANT: begin
          j_q <= j_q + MW'(1);
          in_req_q <= 1'b1;
        end
        S_CHK_INIT: begin
          i_q    <= '0;
          cnt_q  <= '0;
          prog_q <= 1'b0;
        end
        S_CHK_ROW: j_q <= '0;
        S_CHK_SCAN: begin
          if (row_fit) begin
            cnt_q  <= cnt_q + CW'(1);
            prog_q <= 1'b1;
          end
        end
        S_CHK_NEXT: begin
          k_q <= '0;
          j_q <= '0;
          if (!i_last) begin
            i_q <= i_q + PW'(1);
          end else if (!all_done && prog_q) begin
            i_q    <= '0;
            prog_q <= 1'b0;
          end
          // undo the tentative grant on the available side
          if (i_last && !all_done && !prog_q && in_req_q) begin
            for (int j = 0; j < MAX_RES; j++) begin
              if (j < 32'(m_i)) avail_q[j] <= avail_q[j] + req_q[j];
            end
          end
        end
        S_ROLLBACK: j_q <= j_q + MW'(1);
        S_EMIT:     k_q <= k_q + CW'(1);
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    jd_q <= j_q[RW-1:0];
    if (accept && (cmd_i.op == OP_REQUEST) && r_ok) req_q[cmd_r] <= cmd_i.value;
    if (accept && (cmd_i.op == OP_REQUEST) && cmd_i.last && !p_in_use) begin
      fail_st_q <= ST_EXCEEDS;
    end
    if ((state_q == S_REQ_SCAN) && rv_q) begin
      orig_q[jd_q] <= alc_rd;
      if (data_last) fail_st_q <= bad_c ? ST_EXCEEDS : ST_WAIT;
    end
    if (state_q == S_CHK_INIT) begin
      for (int j = 0; j < MAX_RES; j++) work_q[j] <= WW'(avail_q[j]);
      for (int p = 0; p < MAX_PROCS; p++) fin_q[p] <= 1'b0;
    end
    if ((state_q == S_CHK_SCAN) && rv_q) row_q[jd_q] <= alc_rd;
    // a fitting process finishes and releases its allocation
    if ((state_q == S_CHK_SCAN) && row_fit) begin
      for (int j = 0; j < MAX_RES; j++) begin
        if (j < 32'(m_i)) begin
          if (j == int'(jd_q)) work_q[j] <= work_q[j] + WW'(alc_rd);
          else work_q[j] <= work_q[j] + WW'(row_q[j]);
        end
      end
      fin_q[i_q] <= 1'b1;
      seq_q[cnt_q[PW-1:0]] <= i_q;
    end
    if (state_q == S_CHK_NEXT) fail_st_q <= ST_UNSAFE;
    // result word
    if (state_q == S_EMIT) begin
      res_st_q   <= ST_SAFE;
      res_idx_q  <= IDX_W'(seq_q[k_q[PW-1:0]]);
      res_last_q <= (k_q == n_i - CW'(1));
    end else begin
      res_st_q   <= fail_st_q;
      res_idx_q  <= '0;
      res_last_q <= 1'b1;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign res_o.valid    = res_vld_q;
  assign res_o.status   = res_st_q;
  assign res_o.proc_idx = res_idx_q;
  assign res_o.last     = res_last_q;

endmodule

// ===== tb/sv/bankers_safety_allocator_checker.sv =====
// checker of the banker's safety allocator: watches the channels, predicts and compares results
`timescale 1ns / 100ps

module bankers_safety_allocator_checker import bsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [IDX_W-1:0]  process_i,
  input  logic [IDX_W-1:0]  resource_i,
  input  logic [VW-1:0]     value_i,
  input  logic              request_last_i,
  input  logic              result_valid_o,
  input  logic [ST_W-1:0]   status_o,
  input  logic [IDX_W-1:0]  process_index_o,
  input  logic              last_o,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output int                fail_count,
  output int                pending
);

  // one result word
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] proc_idx;
    logic             last;
  } outcome_t;

  outcome_t expected_outcomes[$];

  // mirrored engine state
  logic [CFG_DW-1:0] procs_reg;
  logic [CFG_DW-1:0] res_reg;
  int avail_units [MAX_RES_DEF];
  int claim_units [MAX_PROCS_DEF][MAX_RES_DEF];
  int alloc_units [MAX_PROCS_DEF][MAX_RES_DEF];
  int req_units   [MAX_RES_DEF];

  // registers clamp to 1..bound
  function automatic int procs_used();
    int n;
    n = procs_reg;
    if (n == 0) n = 1;
    if (n > MAX_PROCS_DEF) n = MAX_PROCS_DEF;
    return n;
  endfunction

  function automatic int res_used();
    int m;
    m = res_reg;
    if (m == 0) m = 1;
    if (m > MAX_RES_DEF) m = MAX_RES_DEF;
    return m;
  endfunction

  function automatic void push_outcome(logic [ST_W-1:0] st, int pidx, bit lst);
    outcome_t o;
    o.status   = st;
    o.proc_idx = pidx[IDX_W-1:0];
    o.last     = lst;
    expected_outcomes.push_back(o);
  endfunction

  // safety scan: passes in index order, work vector grows as rows finish
  function automatic bit predict_safety();
    int  n, m, cnt, i, j;
    int  work [MAX_RES_DEF];
    int  order [MAX_PROCS_DEF];
    bit  done [MAX_PROCS_DEF];
    bit  progress, fits;
    n = procs_used();
    m = res_used();
    cnt = 0;
    for (j = 0; j < MAX_RES_DEF; j++) work[j] = avail_units[j];
    for (i = 0; i < MAX_PROCS_DEF; i++) done[i] = 1'b0;
    while (cnt < n) begin
      progress = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!done[i]) begin
          fits = 1'b1;
          for (j = 0; j < m; j++) begin
            if (claim_units[i][j] - alloc_units[i][j] > work[j]) fits = 1'b0;
          end
          if (fits) begin
            for (j = 0; j < m; j++) work[j] += alloc_units[i][j];
            done[i] = 1'b1;
            order[cnt] = i;
            cnt++;
            progress = 1'b1;
          end
        end
      end
      if (!progress) begin
        push_outcome(ST_UNSAFE, 0, 1'b1);
        return 1'b0;
      end
    end
    for (i = 0; i < n; i++) push_outcome(ST_SAFE, order[i], i == n - 1);
    return 1'b1;
  endfunction

  // request evaluation with tentative grant and rollback
  function automatic void predict_request(int p);
    int m, j;
    bit ok;
    m = res_used();
    if (p >= procs_used()) begin
      push_outcome(ST_EXCEEDS, 0, 1'b1);
      return;
    end
    for (j = 0; j < m; j++) begin
      if (req_units[j] > claim_units[p][j] - alloc_units[p][j]) begin
        push_outcome(ST_EXCEEDS, 0, 1'b1);
        return;
      end
    end
    for (j = 0; j < m; j++) begin
      if (req_units[j] > avail_units[j]) begin
        push_outcome(ST_WAIT, 0, 1'b1);
        return;
      end
    end
    for (j = 0; j < m; j++) begin
      avail_units[j] -= req_units[j];
      alloc_units[p][j] += req_units[j];
    end
    ok = predict_safety();
    if (!ok) begin
      for (j = 0; j < m; j++) begin
        avail_units[j] += req_units[j];
        alloc_units[p][j] -= req_units[j];
      end
    end
  endfunction

  // watch channels
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_o;
    if (!rst_ni) begin
      procs_reg = 5;
      res_reg   = 3;
      for (int j = 0; j < MAX_RES_DEF; j++) begin
        avail_units[j] = 0;
        req_units[j]   = 0;
        for (int i = 0; i < MAX_PROCS_DEF; i++) begin
          claim_units[i][j] = 0;
          alloc_units[i][j] = 0;
        end
      end
      expected_outcomes.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      // result word
      if (result_valid_o) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result: status %0d proc %0d last %0d", $realtime,
                   status_o, process_index_o, last_o);
          fail_count++;
        end else begin
          exp_o = expected_outcomes.pop_front();
          if (exp_o.status !== status_o || exp_o.proc_idx !== process_index_o ||
              exp_o.last !== last_o) begin
            $display("%0t: mismatch: expected status %0d proc %0d last %0d, got %0d %0d %0d",
                     $realtime, exp_o.status, exp_o.proc_idx, exp_o.last,
                     status_o, process_index_o, last_o);
            fail_count++;
          end
        end
      end
      // register word
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_NUM_PROCS) procs_reg = cfg_data_i;
        else if (cfg_index_i == CFG_NUM_RES) res_reg = cfg_data_i;
      end
      // command word
      if (start_i && !busy_o) begin
        case (operation_i)
          OP_WR_AVAIL: avail_units[resource_i] = value_i;
          OP_WR_MAX:   claim_units[process_i][resource_i] = value_i;
          OP_WR_ALLOC: alloc_units[process_i][resource_i] = value_i;
          OP_CHECK:    void'(predict_safety());
          OP_REQUEST: begin
            req_units[resource_i] = value_i;
            if (request_last_i) predict_request(process_i);
          end
          default: ;
        endcase
      end
      pending = expected_outcomes.size();
    end
  end

endmodule

// ===== tb/sv/bankers_safety_allocator_core_tb.sv =====
// testbench top of the banker's safety allocator: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module bankers_safety_allocator_core_tb;
  import bsa_pkg::*;

  // unused operation codes, ignored by the engine
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int STALL_LIMIT  = 100000;
  localparam int TARGET_ITEMS = 140;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [OP_W-1:0]   operation_i;
  logic [IDX_W-1:0]  process_i;
  logic [IDX_W-1:0]  resource_i;
  logic [VW-1:0]     value_i;
  logic              request_last_i;
  logic              result_valid_o;
  logic [ST_W-1:0]   status_o;
  logic [IDX_W-1:0]  process_index_o;
  logic              last_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;
  int                fail_count;
  int                pending;
  int                stall_cycles;
  int                item_count;
  bit                idle_on;
  int                procs_now;
  int                res_now;
  logic [MAX_RES_DEF-1:0] req_written;

  bankers_safety_allocator_core DUT (.*);

  bankers_safety_allocator_checker u_checker (.*);

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // one command word; start stays high after acceptance
  task automatic send_word(logic [OP_W-1:0] op, int p, int r, logic [VW-1:0] v, bit lst);
    bit taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    operation_i    <= op;
    process_i      <= p[IDX_W-1:0];
    resource_i     <= r[IDX_W-1:0];
    value_i        <= v;
    request_last_i <= lst;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    if (op == OP_REQUEST) req_written[r] = 1'b1;
    item_count++;
  endtask

  // register write once the engine has drained
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    bit taken;
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_NUM_PROCS) procs_now = (data == 0) ? 1 : (data > 16) ? 16 : data;
    else res_now = (data == 0) ? 1 : (data > 16) ? 16 : data;
  endtask

  // full request: every element in use, last one evaluates
  task automatic send_request(int p, int hi);
    for (int j = 0; j < res_now; j++) begin
      send_word(OP_REQUEST, j, j, VW'($urandom_range(0, hi)), 1'b0);
    end
    send_word(OP_REQUEST, p, res_now - 1, VW'($urandom_range(0, hi)), 1'b1);
  endtask

  // unit counts: mostly small, sometimes extreme or full width
  function automatic logic [VW-1:0] pick_units();
    case ($urandom_range(0, 9))
      0: return VW'($urandom);
      1: return 16'hFFFF;
      default: return VW'($urandom_range(0, 6));
    endcase
  endfunction

  function automatic int pick_index(int used);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, used - 1);
  endfunction

  // one random stimulus item
  task automatic random_item();
    int sel, p, r;
    logic [VW-1:0] v;
    logic [MAX_RES_DEF-1:0] in_use_mask;
    sel = $urandom_range(0, 99);
    p = pick_index(procs_now);
    r = pick_index(res_now);
    in_use_mask = MAX_RES_DEF'((32'd1 << res_now) - 32'd1);
    if (sel < 12) begin
      send_word(OP_WR_AVAIL, p, r, pick_units(), $urandom_range(0, 1));
    end else if (sel < 24) begin
      v = $urandom_range(0, 4);
      send_word(OP_WR_ALLOC, p, r, v, $urandom_range(0, 1));
      send_word(OP_WR_MAX, p, r, v + VW'($urandom_range(0, 5)), $urandom_range(0, 1));
    end else if (sel < 32) begin
      send_word(OP_WR_MAX, p, r, pick_units(), $urandom_range(0, 1));
    end else if (sel < 46) begin
      send_word(OP_CHECK, p, r, VW'($urandom), $urandom_range(0, 1));
    end else if (sel < 86) begin
      send_request(pick_index(procs_now), ($urandom_range(0, 4) == 0) ? 65535 : 3);
    end else if (sel < 92) begin
      send_word(OP_REQUEST, p, r, pick_units(), 1'b0);
    end else if (sel < 96 && (&(req_written | ~in_use_mask))) begin
      send_word(OP_REQUEST, p, r, VW'($urandom_range(0, 2)), 1'b1);
    end else begin
      send_word(OP_UNUSED_LO + OP_W'($urandom_range(0, 2)), p, r, VW'($urandom),
                $urandom_range(0, 1));
    end
  endtask

  // stimulus
  initial begin
    int cfg_procs [8] = '{5, 0, 16, 31, 2, 17, 4, 3};
    int cfg_res   [8] = '{3, 0, 16, 31, 1, 4, 2, 16};
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    operation_i    = OP_WR_AVAIL;
    process_i      = '0;
    resource_i     = '0;
    value_i        = '0;
    request_last_i = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_NUM_PROCS;
    cfg_data_i     = '0;
    stall_cycles   = 0;
    item_count     = 0;
    idle_on        = 1'b1;
    procs_now      = 5;
    res_now        = 3;
    req_written    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every operation, special cases
    send_word(OP_WR_AVAIL, 0, 0, 16'hFFFF, 1'b0);
    send_word(OP_WR_AVAIL, 0, 1, 16'h0000, 1'b1);
    send_word(OP_WR_AVAIL, 0, 2, 16'h0002, 1'b0);
    send_word(OP_WR_MAX, 1, 1, 16'h0001, 1'b0);
    send_word(OP_WR_ALLOC, 2, 1, 16'h0001, 1'b0);
    send_word(OP_CHECK, 15, 15, 16'hFFFF, 1'b1);
    // must wait: fits the claim, not the pool
    send_word(OP_REQUEST, 0, 0, 16'h0000, 1'b0);
    send_word(OP_REQUEST, 0, 2, 16'h0000, 1'b0);
    send_word(OP_REQUEST, 1, 1, 16'h0001, 1'b1);
    // exceeds claim
    send_word(OP_REQUEST, 1, 0, 16'h0001, 1'b1);
    // process outside the count in use
    send_word(OP_REQUEST, 15, 0, 16'h0000, 1'b1);
    // zero request, refused as exceeding the claim: process 2 holds more than it claims
    send_word(OP_REQUEST, 2, 1, 16'h0000, 1'b1);
    // unsafe state, then a request that rolls back
    send_word(OP_WR_MAX, 3, 2, 16'h0005, 1'b0);
    send_word(OP_CHECK, 0, 0, 16'h0000, 1'b0);
    send_word(OP_REQUEST, 0, 1, 16'h0000, 1'b1);
    // ignored codes and writes beyond the count in use
    send_word(OP_UNUSED_LO, 7, 7, 16'hAAAA, 1'b1);
    send_word(OP_UNUSED_HI, 8, 8, 16'h5555, 1'b0);
    send_word(OP_WR_MAX, 15, 15, 16'hFFFF, 1'b1);
    send_word(OP_WR_ALLOC, 15, 15, 16'hFFFF, 1'b1);
    send_word(OP_WR_MAX, 3, 2, 16'h0000, 1'b0);
    send_word(OP_CHECK, 0, 0, 16'h0000, 1'b0);

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_NUM_PROCS, CFG_DW'(cfg_procs[ph]));
      write_reg(CFG_NUM_RES, CFG_DW'(cfg_res[ph]));
      if (ph == 7) idle_on = 1'b0;
      while (item_count < TARGET_ITEMS * (ph + 1) / 8) random_item();
    end
    start_i <= 1'b0;

    // drain and verdict
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
